// ----- rtl/erlm_pkg.sv -----
// Package: widths, CORDIC constants and fixed-point helpers for the Euler rotation block.
`default_nettype none
package erlm_pkg;
  localparam int AngleBits  = 16;
  localparam int CoordBits  = 32;
  localparam int CordicSteps = 24;
  localparam int NumCells   = 9;

  typedef logic [AngleBits-1:0]        angle_t;
  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [33:0]          cq_t;     // CORDIC x, y (Q2.30 with headroom)
  typedef logic signed [32:0]          ph_t;     // CORDIC residual phase
  typedef logic signed [31:0]          q30_t;    // clamped Q2.30 value

  localparam cq_t CordicX0 = 34'sd652032874;
  localparam q30_t Q30One  = 32'sd1073741824;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sincos_t;

  typedef struct packed {
    coord_t [NumCells-1:0] ent;
  } mat_t;

  typedef struct packed {
    q30_t [NumCells-1:0] ent;
  } rot_t;

  typedef struct packed {
    angle_t angle_alpha;
    angle_t angle_beta;
    angle_t angle_gamma;
    coord_t in_r0_x; coord_t in_r0_y; coord_t in_r0_z;
    coord_t in_r1_x; coord_t in_r1_y; coord_t in_r1_z;
    coord_t in_r2_x; coord_t in_r2_y; coord_t in_r2_z;
  } erlm_in_t;

  typedef struct packed {
    coord_t out_r0_x; coord_t out_r0_y; coord_t out_r0_z;
    coord_t out_r1_x; coord_t out_r1_y; coord_t out_r1_z;
    coord_t out_r2_x; coord_t out_r2_y; coord_t out_r2_z;
  } erlm_out_t;

  function automatic ph_t atan_tab(input logic [4:0] i);
    case (i)
      5'd0: return 33'sd536870912;   5'd1: return 33'sd316933406;
      5'd2: return 33'sd167458907;   5'd3: return 33'sd85004756;
      5'd4: return 33'sd42667331;    5'd5: return 33'sd21354465;
      5'd6: return 33'sd10679838;    5'd7: return 33'sd5340245;
      5'd8: return 33'sd2670163;     5'd9: return 33'sd1335087;
      5'd10: return 33'sd667544;     5'd11: return 33'sd333772;
      5'd12: return 33'sd166886;     5'd13: return 33'sd83443;
      5'd14: return 33'sd41722;      5'd15: return 33'sd20861;
      5'd16: return 33'sd10430;      5'd17: return 33'sd5215;
      5'd18: return 33'sd2608;       5'd19: return 33'sd1304;
      5'd20: return 33'sd652;        5'd21: return 33'sd326;
      5'd22: return 33'sd163;        5'd23: return 33'sd81;
      default: return 33'sd0;
    endcase
  endfunction

  // Q30 product rounded half up; inputs lie within [-2^30, 2^30].
  function automatic logic signed [32:0] qmul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 33'(p >>> 30);
  endfunction

  function automatic q30_t clamp30(input logic signed [33:0] v);
    if (v > 34'sd1073741824) return Q30One;
    if (v < -34'sd1073741824) return -Q30One;
    return 32'(v);
  endfunction
endpackage
`default_nettype wire

// ----- rtl/erlm_if.sv -----
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface erlm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/erlm_cordic.sv -----
// Pipelined rotation-mode CORDIC lane producing sine and cosine in Q2.30.
`default_nettype none
module erlm_cordic (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire erlm_pkg::angle_t  angle,
  output erlm_pkg::sincos_t      sc
);
  import erlm_pkg::*;

  cq_t  x [CordicSteps+1];
  cq_t  y [CordicSteps+1];
  ph_t  z [CordicSteps+1];
  logic flip [CordicSteps+1];

  logic [31:0] ph;
  logic [31:0] ph_adj;
  logic        fl0;

  always_comb begin
    ph     = {angle, {(32-AngleBits){1'b0}}};
    fl0    = ph[31] ^ ph[30];
    ph_adj = fl0 ? ph + 32'h8000_0000 : ph;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CordicX0;
      y[0]    <= '0;
      z[0]    <= 33'(signed'(ph_adj));
      flip[0] <= fl0;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][32]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_tab(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_tab(5'(i));
        end
      end
    end
  end

  q30_t cx, cy;
  always_comb begin
    cx = clamp30(x[CordicSteps]);
    cy = clamp30(y[CordicSteps]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.c <= flip[CordicSteps] ? -cx : cx;
      sc.s <= flip[CordicSteps] ? -cy : cy;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/erlm_rotgen.sv -----
// Builds the clamped rotation matrix from three sine/cosine pairs over three stages.
`default_nettype none
module erlm_rotgen (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire erlm_pkg::sincos_t a,
  input  wire erlm_pkg::sincos_t b,
  input  wire erlm_pkg::sincos_t g,
  output erlm_pkg::rot_t         rot
);
  import erlm_pkg::*;

  // Stage 1: two-way products, alpha and gamma terms delayed alongside.
  q30_t sasb, casb, cbcg, cbsg, nsb, sacb, cacb, s1sa, s1ca, s1sg, s1cg;
  always_ff @(posedge clk) begin
    if (en) begin
      sasb <= 32'(qmul(a.s, b.s));
      casb <= 32'(qmul(a.c, b.s));
      cbcg <= clamp30(34'(qmul(b.c, g.c)));
      cbsg <= clamp30(34'(qmul(b.c, g.s)));
      nsb  <= clamp30(-34'(b.s));
      sacb <= clamp30(34'(qmul(a.s, b.c)));
      cacb <= clamp30(34'(qmul(a.c, b.c)));
      s1sa <= a.s; s1ca <= a.c; s1sg <= g.s; s1cg <= g.c;
    end
  end

  // Stage 2: products feeding the sums.
  logic signed [32:0] p10a, p10b, p11a, p11b, p20a, p20b, p21a, p21b;
  q30_t d00, d01, d02, d12, d22;
  always_ff @(posedge clk) begin
    if (en) begin
      p10a <= qmul(sasb, s1cg); p10b <= qmul(s1ca, s1sg);
      p11a <= qmul(sasb, s1sg); p11b <= qmul(s1ca, s1cg);
      p20a <= qmul(casb, s1cg); p20b <= qmul(s1sa, s1sg);
      p21a <= qmul(casb, s1sg); p21b <= qmul(s1sa, s1cg);
      d00 <= cbcg; d01 <= cbsg; d02 <= nsb; d12 <= sacb; d22 <= cacb;
    end
  end

  // Stage 3: sums and clamps.
  always_ff @(posedge clk) begin
    if (en) begin
      rot.ent[0] <= d00;
      rot.ent[1] <= d01;
      rot.ent[2] <= d02;
      rot.ent[3] <= clamp30(34'(p10a) - 34'(p10b));
      rot.ent[4] <= clamp30(34'(p11a) + 34'(p11b));
      rot.ent[5] <= d12;
      rot.ent[6] <= clamp30(34'(p20a) + 34'(p20b));
      rot.ent[7] <= clamp30(34'(p21a) - 34'(p21b));
      rot.ent[8] <= d22;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/erlm_dot.sv -----
// One output lane: three-term dot product of a rotation row with a lattice column.
`default_nettype none
module erlm_dot (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire erlm_pkg::q30_t   r0,
  input  wire erlm_pkg::q30_t   r1,
  input  wire erlm_pkg::q30_t   r2,
  input  wire erlm_pkg::coord_t l0,
  input  wire erlm_pkg::coord_t l1,
  input  wire erlm_pkg::coord_t l2,
  output erlm_pkg::coord_t      res
);
  import erlm_pkg::*;

  logic signed [63:0] pr0, pr1, pr2;
  logic signed [65:0] sum;
  logic signed [65:0] sh;

  always_ff @(posedge clk) begin
    if (en) begin
      pr0 <= 64'(r0) * 64'(l0);
      pr1 <= 64'(r1) * 64'(l1);
      pr2 <= 64'(r2) * 64'(l2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) sum <= 66'(pr0) + 66'(pr1) + 66'(pr2) + 66'sd536870912;
  end

  always_comb sh = sum >>> 30;

  // Saturate to the coordinate range.
  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > 66'(coord_t'({1'b0, {(CoordBits-1){1'b1}}})))
        res <= {1'b0, {(CoordBits-1){1'b1}}};
      else if (sh < 66'(coord_t'({1'b1, {(CoordBits-1){1'b0}}})))
        res <= {1'b1, {(CoordBits-1){1'b0}}};
      else
        res <= CoordBits'(sh);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/euler_rotate_lattice_matrix.sv -----
// Top level: Euler-angle rotation of a 3x3 lattice matrix, one item per unstalled cycle.
//  channel | dir | payload
//  in_ch   | in  | angle_alpha/beta/gamma, in_rI_x/y/z
//  out_ch  | out | out_rI_x/y/z
// One item is taken per cycle unless the output stalls; stages are 26 CORDIC, 3 matrix
// build and 3 dot-product lane, with the lattice delayed alongside the angle path.
// The whole pipeline advances only when the last stage is empty or being taken,
// so a stall on the output holds every stage. Reset clears the valid bits only.
`default_nettype none

module euler_rotate_lattice_matrix (
  input  wire logic clk,
  input  wire logic rst,
  erlm_if.sink      in_ch,
  erlm_if.source    out_ch
);
  import erlm_pkg::*;

  localparam int RotLat = CordicSteps + 2 + 3;   // angle to rotation matrix
  localparam int Lat    = RotLat + 3;            // through dot lanes

  logic            en;
  logic [Lat-1:0]  vld;
  erlm_in_t        din;
  mat_t            lat [RotLat];
  sincos_t         sca, scb, scg;
  rot_t            rot;
  coord_t          res [NumCells];

  assign din = in_ch.data;
  assign en  = !vld[Lat-1] || out_ch.ready;
  assign in_ch.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_ch.valid};
  end

  // Lattice delay line matching the rotation matrix path.
  always_ff @(posedge clk) begin
    if (en) lat[0] <= '{ent: {din.in_r2_z, din.in_r2_y, din.in_r2_x,
                              din.in_r1_z, din.in_r1_y, din.in_r1_x,
                              din.in_r0_z, din.in_r0_y, din.in_r0_x}};
  end
  for (genvar d = 0; d < RotLat-1; d++) begin : g_dly
    always_ff @(posedge clk) if (en) lat[d+1] <= lat[d];
  end

  erlm_cordic u_ca (.clk, .en, .angle(din.angle_alpha), .sc(sca));
  erlm_cordic u_cb (.clk, .en, .angle(din.angle_beta),  .sc(scb));
  erlm_cordic u_cg (.clk, .en, .angle(din.angle_gamma), .sc(scg));

  erlm_rotgen u_rot (.clk, .en, .a(sca), .b(scb), .g(scg), .rot);

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      erlm_dot u_dot (
        .clk, .en,
        .r0(rot.ent[i*3]), .r1(rot.ent[i*3+1]), .r2(rot.ent[i*3+2]),
        .l0(lat[RotLat-1].ent[j]), .l1(lat[RotLat-1].ent[3+j]),
        .l2(lat[RotLat-1].ent[6+j]),
        .res(res[i*3+j])
      );
    end
  end

  assign out_ch.valid = vld[Lat-1];
  assign out_ch.data  = '{out_r0_x: res[0], out_r0_y: res[1], out_r0_z: res[2],
                          out_r1_x: res[3], out_r1_y: res[4], out_r1_z: res[5],
                          out_r2_x: res[6], out_r2_y: res[7], out_r2_z: res[8]};

  // A stalled result must stay put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  // Input is taken whenever the output side is free.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  // An output stall also blocks the input.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken during output stall");
endmodule
`default_nettype wire
